>>> sv/bspd_pkg.sv
// ----------------------------------------------------------------------------
// bspd_pkg: shared types and constants of the bus slave packet deframer
// Byte codes, packet kinds, parser states and the command and status
// groups that join the controller to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package bspd_pkg;

    localparam logic [7:0] HEAD_SERVICE = 8'h01;
    localparam logic [7:0] HEAD_REGULAR = 8'h02;
    localparam logic [7:0] HEAD_GROUP   = 8'h03;
    localparam logic [7:0] ESC_PREFIX   = 8'h00;
    localparam logic [7:0] ESC_SHIFT    = 8'h04;
    localparam logic [7:0] REPLY_BIT    = 8'h80;

    localparam logic [1:0] KIND_REGULAR = 2'd0;
    localparam logic [1:0] KIND_SERVICE = 2'd1;
    localparam logic [1:0] KIND_GROUP   = 2'd2;

    localparam logic [6:0] DEVICE_ADDRESS_RESET = 7'd1;

    typedef enum logic [2:0] {
        ST_READY,
        ST_GRP_ADDR,
        ST_GRP_MASK,
        ST_ADDR,
        ST_LENGTH,
        ST_DATA,
        ST_CHECKSUM,
        ST_DRAIN
    } parse_state_t;

    // Controller to datapath
    typedef struct packed {
        logic beat;         // input byte accepted this cycle
        logic load_kind;    // header byte: take the packet kind
        logic grp_addr;     // group address byte: hold it, start the sum
        logic grp_mask;     // mask byte: hold it, add to the sum
        logic addr;         // exact address byte: start the sum
        logic length;       // length byte: hold it, add to sum, clear fill
        logic store;        // payload byte
        logic start_drain;  // good checksum: rewind the read pointer
        logic drain_load;   // move one result into the output register
    } bspd_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic hdr_addr;     // service or regular header
        logic hdr_group;    // group header
        logic esc_prefix;   // raw escape byte
        logic reply;        // unescaped byte has the reply bit
        logic addr_ok;      // exact address match
        logic mask_ok;      // masked group address match
        logic len_zero;     // length byte is zero
        logic fill_hit;     // fill count after this byte equals the length
        logic sum_ok;       // checksum closes the sum to zero
        logic out_free;     // output register can take a result
        logic drain_last;   // result being drained is the last one
    } bspd_status_t;

endpackage

`default_nettype wire

>>> sv/bspd_if.sv
// ----------------------------------------------------------------------------
// bspd_if: channel interfaces of the bus slave packet deframer
// Received byte channel, result channel and configuration write channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface bspd_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface bspd_res_if;
    logic       valid;
    logic       ready;
    logic [1:0] packet_kind;
    logic [7:0] payload_byte;
    logic [3:0] byte_index;
    logic       payload_empty;
    logic       last_of_packet;

    modport source (output valid, output packet_kind, output payload_byte,
                    output byte_index, output payload_empty,
                    output last_of_packet, input ready);
    modport sink   (input valid, input packet_kind, input payload_byte,
                    input byte_index, input payload_empty,
                    input last_of_packet, output ready);
endinterface

interface bspd_cfg_if;
    logic       valid;
    logic       ready;
    logic [6:0] device_address;

    modport source (output valid, output device_address, input ready);
    modport sink   (input valid, input device_address, output ready);
endinterface

`default_nettype wire

>>> sv/bspd_ctrl.sv
// ----------------------------------------------------------------------------
// bspd_ctrl: parser controller
// Walks the header, address, mask, length, payload and checksum fields,
// then drains the buffered payload one result per cycle while the receiver takes them.
// ----------------------------------------------------------------------------
`default_nettype none

module bspd_ctrl (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     rx_valid,
    output logic                    rx_ready,
    input  wire bspd_pkg::bspd_status_t status,
    output bspd_pkg::bspd_cmd_t     cmd
);
    import bspd_pkg::*;

    parse_state_t state_reg;
    parse_state_t state_next;
    logic         beat;
    logic         data_beat;

    assign rx_ready  = (state_reg != ST_DRAIN);
    assign beat      = rx_valid && rx_ready;
    assign data_beat = beat && !status.hdr_addr && !status.hdr_group && !status.esc_prefix;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_READY;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        if (state_reg == ST_DRAIN)
        begin
            if (status.out_free && status.drain_last)
            begin
                state_next = ST_READY;
            end
        end
        else if (beat)
        begin
            priority if (status.hdr_addr)
            begin
                state_next = ST_ADDR;
            end
            else if (status.hdr_group)
            begin
                state_next = ST_GRP_ADDR;
            end
            else if (status.esc_prefix)
            begin
                state_next = state_reg;
            end
            else
            begin
                unique case (state_reg)
                    ST_GRP_ADDR: state_next = status.reply ? ST_READY : ST_GRP_MASK;
                    ST_GRP_MASK: state_next = status.mask_ok ? ST_LENGTH : ST_READY;
                    ST_ADDR:     state_next = status.addr_ok ? ST_LENGTH : ST_READY;
                    ST_LENGTH:   state_next = status.len_zero ? ST_CHECKSUM : ST_DATA;
                    ST_DATA:     state_next = status.fill_hit ? ST_CHECKSUM : ST_DATA;
                    ST_CHECKSUM: state_next = status.sum_ok ? ST_DRAIN : ST_READY;
                    default:     state_next = ST_READY;
                endcase
            end
        end
    end

    // Commands
    always_comb
    begin
        cmd             = '0;
        cmd.beat        = beat;
        cmd.load_kind   = beat && (status.hdr_addr || status.hdr_group);
        cmd.grp_addr    = data_beat && (state_reg == ST_GRP_ADDR) && !status.reply;
        cmd.grp_mask    = data_beat && (state_reg == ST_GRP_MASK) && status.mask_ok;
        cmd.addr        = data_beat && (state_reg == ST_ADDR) && status.addr_ok;
        cmd.length      = data_beat && (state_reg == ST_LENGTH);
        cmd.store       = data_beat && (state_reg == ST_DATA);
        cmd.start_drain = data_beat && (state_reg == ST_CHECKSUM) && status.sum_ok;
        cmd.drain_load  = (state_reg == ST_DRAIN) && status.out_free;
    end

endmodule

`default_nettype wire

>>> sv/bspd_datapath.sv
// ----------------------------------------------------------------------------
// bspd_datapath: deframer datapath
// Unescaping, address checks, running checksum, payload buffer and the
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bspd_datapath #(
    parameter int BUFFER_DEPTH = 16
) (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire  [7:0]              rx_byte,
    input  wire                     cfg_we,
    input  wire  [6:0]              cfg_device_address,
    input  wire bspd_pkg::bspd_cmd_t cmd,
    output bspd_pkg::bspd_status_t  status,
    input  wire                     out_ready,
    output logic                    out_valid,
    output logic [1:0]              packet_kind,
    output logic [7:0]              payload_byte,
    output logic [3:0]              byte_index,
    output logic                    payload_empty,
    output logic                    last_of_packet
);
    import bspd_pkg::*;

    localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int FW = $clog2(BUFFER_DEPTH + 1);

    logic [6:0]    dev_addr_reg;
    logic          esc_reg;
    logic [1:0]    kind_reg;
    logic [7:0]    group_reg;
    logic [7:0]    length_reg;
    logic [FW-1:0] fill_reg;
    logic [7:0]    sum_reg;
    logic [7:0]    mem [BUFFER_DEPTH];
    logic [AW-1:0] rd_ptr_reg;
    logic [AW-1:0] rd_ptr_next;
    logic [7:0]    rd_data_reg;

    logic          out_valid_reg;
    logic [1:0]    kind_out_reg;
    logic [7:0]    byte_out_reg;
    logic [3:0]    index_out_reg;
    logic          empty_out_reg;
    logic          last_out_reg;

    logic [7:0]    d;
    logic [7:0]    dev8;
    logic          fill_room;
    logic [FW-1:0] fill_after;
    logic          drain_empty;
    logic          drain_last;

    assign d           = esc_reg ? (rx_byte - ESC_SHIFT) : rx_byte;
    assign dev8        = {1'b0, dev_addr_reg};
    assign fill_room   = (fill_reg < FW'(BUFFER_DEPTH));
    assign fill_after  = fill_reg + FW'(fill_room);
    assign drain_empty = (fill_reg == '0);
    assign drain_last  = drain_empty || ((FW'(rd_ptr_reg) + FW'(1)) == fill_reg);

    always_comb
    begin
        status            = '0;
        status.hdr_addr   = (rx_byte == HEAD_SERVICE) || (rx_byte == HEAD_REGULAR);
        status.hdr_group  = (rx_byte == HEAD_GROUP);
        status.esc_prefix = (rx_byte == ESC_PREFIX);
        status.reply      = ((d & REPLY_BIT) != 8'h00);
        status.addr_ok    = (d == dev8);
        status.mask_ok    = ((d & group_reg) == (d & dev8));
        status.len_zero   = (d == 8'h00);
        status.fill_hit   = (8'(fill_after) == length_reg);
        status.sum_ok     = ((d + sum_reg) == 8'h00);
        status.out_free   = !out_valid_reg || out_ready;
        status.drain_last = drain_last;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_addr_reg <= DEVICE_ADDRESS_RESET;
            esc_reg      <= 1'b0;
            kind_reg     <= KIND_REGULAR;
            group_reg    <= 8'h00;
            length_reg   <= 8'h00;
            fill_reg     <= '0;
            sum_reg      <= 8'h00;
            rd_ptr_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                dev_addr_reg <= cfg_device_address;
            end
            if (cmd.beat)
            begin
                priority if (status.hdr_addr || status.hdr_group)
                begin
                    esc_reg <= 1'b0;
                end
                else if (status.esc_prefix)
                begin
                    esc_reg <= 1'b1;
                end
                else
                begin
                    esc_reg <= 1'b0;
                end
            end
            if (cmd.load_kind)
            begin
                priority if (rx_byte == HEAD_SERVICE)
                begin
                    kind_reg <= KIND_SERVICE;
                end
                else if (rx_byte == HEAD_REGULAR)
                begin
                    kind_reg <= KIND_REGULAR;
                end
                else
                begin
                    kind_reg <= KIND_GROUP;
                end
            end
            if (cmd.grp_addr)
            begin
                group_reg <= d;
                sum_reg   <= d;
            end
            if (cmd.grp_mask)
            begin
                group_reg <= d;
                sum_reg   <= sum_reg + d;
            end
            if (cmd.addr)
            begin
                sum_reg <= d;
            end
            if (cmd.length)
            begin
                sum_reg    <= sum_reg + d;
                length_reg <= d;
                fill_reg   <= '0;
            end
            if (cmd.store && fill_room)
            begin
                sum_reg  <= sum_reg + d;
                fill_reg <= fill_after;
            end
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    // Rewind on a good checksum; advance on each drained result, but
    // hold at the last one so the read address stays inside the buffer.
    always_comb
    begin
        rd_ptr_next = rd_ptr_reg;
        if (cmd.start_drain)
        begin
            rd_ptr_next = '0;
        end
        else if (cmd.drain_load && !drain_last)
        begin
            rd_ptr_next = rd_ptr_reg + AW'(1);
        end
    end

    // Payload buffer: one write port, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.store && fill_room)
        begin
            mem[fill_reg[AW-1:0]] <= d;
        end
        rd_data_reg <= mem[rd_ptr_next];
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.drain_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.drain_load)
        begin
            kind_out_reg  <= kind_reg;
            byte_out_reg  <= drain_empty ? 8'h00 : rd_data_reg;
            index_out_reg <= drain_empty ? 4'd0 : 4'(rd_ptr_reg);
            empty_out_reg <= drain_empty;
            last_out_reg  <= drain_last;
        end
    end

    assign out_valid      = out_valid_reg;
    assign packet_kind    = kind_out_reg;
    assign payload_byte   = byte_out_reg;
    assign byte_index     = index_out_reg;
    assign payload_empty  = empty_out_reg;
    assign last_of_packet = last_out_reg;

endmodule

`default_nettype wire

>>> sv/bus_slave_packet_deframer.sv
// ----------------------------------------------------------------------------
// bus_slave_packet_deframer: bus slave receive deframer
// Parses received bus bytes and emits the payload of packets addressed here.
// ----------------------------------------------------------------------------
// Usage:
//   rx   - one received serial byte per beat. Headers 0x01/0x02/0x03 restart
//          parsing anywhere; 0x00 escapes the next byte (minus 4).
//   res  - one beat per payload byte of a good packet, in order, with its
//          kind and index; the final beat carries last_of_packet. A good
//          packet with no payload gives a single beat with payload_empty.
//   cfg  - write of device_address; write only while the block is idle.
// Timing:
//   A byte that does not close a packet is accepted with rx.ready held high.
//   A good checksum starts a drain of the payload buffer: the first result
//   passes the state register and then the output register, then one result
//   per cycle leaves the output register while the receiver takes them, and
//   rx.ready stays low until the last result is loaded. The drain rate is
//   set by the single registered read port of the buffer.
//   A stalled receiver holds the output register and freezes the drain.
// Reset:
//   rst_n clears the parser to wait for a header and sets device_address to
//   1. The payload buffer is not cleared; only written entries are read.
// ----------------------------------------------------------------------------
`default_nettype none

module bus_slave_packet_deframer #(
    parameter int BUFFER_DEPTH = 16
) (
    input wire         clk,
    input wire         rst_n,
    bspd_rx_if.sink    rx,
    bspd_res_if.source res,
    bspd_cfg_if.sink   cfg
);
    import bspd_pkg::*;

    bspd_cmd_t    cmd;
    bspd_status_t status;

    // Configuration writes are always taken.
    assign cfg.ready = 1'b1;

    // Sequence the fields and the drain.
    bspd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx_valid (rx.valid),
        .rx_ready (rx.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Unescape, check, sum, buffer and present results.
    bspd_datapath #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_datapath (
        .clk                (clk),
        .rst_n              (rst_n),
        .rx_byte            (rx.rx_byte),
        .cfg_we             (cfg.valid && cfg.ready),
        .cfg_device_address (cfg.device_address),
        .cmd                (cmd),
        .status             (status),
        .out_ready          (res.ready),
        .out_valid          (res.valid),
        .packet_kind        (res.packet_kind),
        .payload_byte       (res.payload_byte),
        .byte_index         (res.byte_index),
        .payload_empty      (res.payload_empty),
        .last_of_packet     (res.last_of_packet)
    );

    // A good checksum must block further input while the drain runs.
    a_drain_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start_drain |=> !rx.ready)
        else $error("input accepted at the start of a drain");

    // A result that is not the last one means the drain is still running.
    a_mid_packet_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && !res.last_of_packet) |-> !rx.ready)
        else $error("input ready while a packet is part-way out");

    // An empty packet is a single, last, zero result.
    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.payload_empty) |->
            (res.last_of_packet && (res.payload_byte == 8'h00) &&
             (res.byte_index == 4'd0)))
        else $error("malformed empty-packet result");

endmodule

`default_nettype wire
